// ===== rtl/core/hsfp_pkg.sv =====
package hsfp_pkg;

  localparam int ByteW    = 8;
  localparam int TimeW    = 32;
  localparam int PendW    = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 2'd2;

  localparam logic [TimeW-1:0] TIMEOUT_RESET       = 32'd100;
  localparam logic [ByteW-1:0] HEADER_FIRST_RESET  = 8'hFA;
  localparam logic [ByteW-1:0] HEADER_SECOND_RESET = 8'hDA;

  localparam logic MODE_DATA   = 1'b0;
  localparam logic MODE_EXPIRE = 1'b1;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] data_byte;
    logic [TimeW-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] frame_byte;
    logic             last_of_frame;
    logic             expired;
    logic [PendW-1:0] pending_count;
  } result_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic             kind;
    logic             expired;
    logic [PendW-1:0] pending_count;
    logic             bank;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_FRAME
  } back_state_t;

endpackage

// ===== rtl/core/hsfp_ram.sv =====
module hsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hsfp_front.sv =====
module hsfp_front import hsfp_pkg::*; #(
  parameter int FRAME_SIZE = 8,
  localparam int IW = $clog2(FRAME_SIZE),
  localparam int AW = IW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [ByteW-1:0]    ram_wdata,
  output logic                cmd_push,
  output cmd_t                cmd,
  input  queue_status_t       cmd_status,
  input  logic                frame_done
);

  logic [TimeW-1:0] tmo_limit;
  logic [ByteW-1:0] header_first;
  logic [ByteW-1:0] header_second;

  logic [IW-1:0]    fill, fill_next;
  logic [TimeW-1:0] last_time, last_time_next;
  logic             time_valid, time_valid_next;
  logic             bank, bank_next;
  logic [1:0]       frames_held, frames_held_next;

  logic             accept;
  logic             hdr_hit;
  logic             stale;
  logic             frame_complete;
  logic [TimeW-1:0] age;

  // Two banks: stall once both hold completed frames awaiting the back
  assign full    = cmd_status.full || (frames_held == 2'd2);
  assign accept  = push && !full;
  assign hdr_hit = (item.data_byte == header_first) || (item.data_byte == header_second);
  assign age     = item.now_time - last_time;
  assign stale   = time_valid && (fill != '0) && (age >= tmo_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo_limit     <= TIMEOUT_RESET;
      header_first  <= HEADER_FIRST_RESET;
      header_second <= HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIMEOUT:       tmo_limit     <= cfg_data;
        CFG_HEADER_FIRST:  header_first  <= cfg_data[ByteW-1:0];
        CFG_HEADER_SECOND: header_second <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_next       = fill;
    last_time_next  = last_time;
    time_valid_next = time_valid;
    bank_next       = bank;
    frame_complete  = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = {bank, fill};
    ram_wdata       = item.data_byte;
    cmd_push        = 1'b0;
    cmd             = '0;
    if (accept) begin
      if (item.mode == MODE_EXPIRE) begin
        if (stale) begin
          fill_next       = '0;
          time_valid_next = 1'b0;
        end
        cmd_push          = 1'b1;
        cmd.kind          = KIND_EXPIRE;
        cmd.expired       = stale;
        cmd.pending_count = PendW'(fill_next);
      end else if (hdr_hit) begin
        ram_we          = 1'b1;
        ram_waddr       = {bank, IW'(0)};
        fill_next       = IW'(1);
        last_time_next  = item.now_time;
        time_valid_next = 1'b1;
      end else if (fill != '0) begin
        ram_we          = 1'b1;
        last_time_next  = item.now_time;
        time_valid_next = 1'b1;
        if (fill == IW'(FRAME_SIZE - 1)) begin
          // Frame full: hand the bank to the back and switch banks
          frame_complete  = 1'b1;
          fill_next       = '0;
          time_valid_next = 1'b0;
          bank_next       = ~bank;
          cmd_push        = 1'b1;
          cmd.kind        = KIND_FRAME;
          cmd.bank        = bank;
        end else begin
          fill_next = fill + IW'(1);
        end
      end
    end
  end

  always_comb begin
    case ({frame_complete, frame_done})
      2'b10:   frames_held_next = frames_held + 2'd1;
      2'b01:   frames_held_next = frames_held - 2'd1;
      default: frames_held_next = frames_held;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      last_time   <= '0;
      time_valid  <= 1'b0;
      bank        <= 1'b0;
      frames_held <= 2'd0;
    end else begin
      fill        <= fill_next;
      last_time   <= last_time_next;
      time_valid  <= time_valid_next;
      bank        <= bank_next;
      frames_held <= frames_held_next;
    end
  end

endmodule

// ===== rtl/core/hsfp_cmd_queue.sv =====
module hsfp_cmd_queue import hsfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  cmd_t          wr_cmd,
  input  logic          rd,
  output cmd_t          head,
  output queue_status_t status
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// ===== rtl/core/hsfp_back.sv =====
module hsfp_back import hsfp_pkg::*; #(
  parameter int FRAME_SIZE = 8,
  localparam int IW = $clog2(FRAME_SIZE),
  localparam int AW = IW + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd_head,
  input  queue_status_t    cmd_status,
  output logic             cmd_pop,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [ByteW-1:0] ram_rdata,
  output logic             frame_done,
  output logic             empty,
  input  logic             pop,
  output result_t          result
);

  localparam int OutDepth = 4;
  localparam int OPW      = $clog2(OutDepth);
  localparam int OCW      = OPW + 1;

  back_state_t      state, state_next;
  logic [IW-1:0]    idx, idx_next;
  logic             cur_bank, cur_bank_next;

  logic             credit;
  logic             issue;
  logic             issue_expire;
  logic             issue_last;

  logic             pend;
  logic             pend_expire;
  logic             pend_last;
  logic             pend_expired;
  logic [PendW-1:0] pend_pending;

  result_t          out_slots [OutDepth];
  logic [OPW-1:0]   out_wp;
  logic [OPW-1:0]   out_rp;
  logic [OCW-1:0]   out_count;
  logic             out_pop;
  result_t          out_entry;

  // Room for what is queued plus the read in flight
  assign credit = (out_count + OCW'(pend)) < OCW'(OutDepth);

  always_comb begin
    state_next = state;
    case (state)
      BACK_IDLE: begin
        if (!cmd_status.empty && credit && cmd_head.kind == KIND_FRAME) begin
          state_next = BACK_FRAME;
        end
      end
      BACK_FRAME: begin
        if (credit && idx == IW'(FRAME_SIZE - 1)) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = 1'b0;
    issue         = 1'b0;
    issue_expire  = 1'b0;
    issue_last    = 1'b0;
    frame_done    = 1'b0;
    ram_raddr     = {cur_bank, idx};
    idx_next      = idx;
    cur_bank_next = cur_bank;
    case (state)
      BACK_IDLE: begin
        if (!cmd_status.empty && credit) begin
          cmd_pop = 1'b1;
          issue   = 1'b1;
          if (cmd_head.kind == KIND_EXPIRE) begin
            issue_expire = 1'b1;
          end else begin
            ram_raddr     = {cmd_head.bank, IW'(0)};
            cur_bank_next = cmd_head.bank;
            idx_next      = IW'(1);
          end
        end
      end
      BACK_FRAME: begin
        if (credit) begin
          issue = 1'b1;
          if (idx == IW'(FRAME_SIZE - 1)) begin
            issue_last = 1'b1;
            frame_done = 1'b1;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign ram_re = issue && !issue_expire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BACK_IDLE;
      idx      <= '0;
      cur_bank <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      cur_bank <= cur_bank_next;
      pend     <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_expire  <= issue_expire;
      pend_last    <= issue_last;
      pend_expired <= cmd_head.expired;
      pend_pending <= cmd_head.pending_count;
    end
  end

  always_comb begin
    out_entry = '0;
    if (pend_expire) begin
      out_entry.kind          = KIND_EXPIRE;
      out_entry.expired       = pend_expired;
      out_entry.pending_count = pend_pending;
    end else begin
      out_entry.kind          = KIND_FRAME;
      out_entry.frame_byte    = ram_rdata;
      out_entry.last_of_frame = pend_last;
    end
  end

  assign empty   = (out_count == '0);
  assign out_pop = pop && !empty;
  assign result  = out_slots[out_rp];

  always_ff @(posedge clk) begin
    if (pend) begin
      out_slots[out_wp] <= out_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wp    <= '0;
      out_rp    <= '0;
      out_count <= '0;
    end else begin
      if (pend) begin
        out_wp <= out_wp + OPW'(1);
      end
      if (out_pop) begin
        out_rp <= out_rp + OPW'(1);
      end
      out_count <= out_count + OCW'(pend) - OCW'(out_pop);
    end
  end

endmodule

// ===== rtl/core/header_sync_fixed_frame_parser.sv =====
// Channel  | Transfer when           | Payload
// ---------+-------------------------+-----------------------------------------
// input    | push && !full           | item   (mode, data_byte, now_time)
// result   | pop && !empty           | result (kind, frame_byte, last_of_frame,
//          |                         |         expired, pending_count)
// config   | cfg_write               | cfg_index, cfg_data
//
// Input transactions are taken one per cycle while full is low. A completed
// frame drains at one byte per cycle through the frame RAM read port while the
// output queue has room, and meanwhile the front keeps filling the other RAM bank.
// full rises when both banks hold completed frames not yet drained, or the
// two-entry command queue is full. Results wait in a four-entry output queue.
// Reset is synchronous and clears control state at once; there is no clearing
// pass over the frame RAM, every emitted frame is written in full first.
module header_sync_fixed_frame_parser import hsfp_pkg::*; #(
  parameter int FRAME_SIZE = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output logic                empty,
  input  logic                pop,
  output result_t             result
);

  localparam int IW = $clog2(FRAME_SIZE);
  localparam int AW = IW + 1;

  // Front to RAM: bank bit on top, byte index below
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  // Front to back through the command queue
  logic             cmd_push;
  cmd_t             cmd;
  logic             cmd_pop;
  cmd_t             cmd_head;
  queue_status_t    cmd_status;
  logic             frame_done;

  // Classify bytes and expiry checks, fill frames, track time
  hsfp_front #(.FRAME_SIZE(FRAME_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .cmd_status (cmd_status),
    .frame_done (frame_done)
  );

  // Two frame banks, one written by the front, one drained by the back
  hsfp_ram #(.WIDTH(ByteW), .DEPTH(2 ** AW)) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold commands in order so expiry answers follow earlier frames
  hsfp_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_cmd (cmd),
    .rd     (cmd_pop),
    .head   (cmd_head),
    .status (cmd_status)
  );

  // Drain frames byte by byte and emit expiry answers
  hsfp_back #(.FRAME_SIZE(FRAME_SIZE)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_head   (cmd_head),
    .cmd_status (cmd_status),
    .cmd_pop    (cmd_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .frame_done (frame_done),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== rtl/core/hsfp_checker.sv =====
module hsfp_checker import hsfp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // Reset leaves no result waiting and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result queue not empty or input blocked after reset");

  // Frame bytes carry no expiry information
  a_frame_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_FRAME) |-> (!result.expired && result.pending_count == '0))
    else $error("frame byte with expiry fields set");

  // Expiry answers carry no frame byte
  a_expire_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_EXPIRE) |-> (result.frame_byte == '0 && !result.last_of_frame))
    else $error("expiry answer with frame fields set");

  // A dropped partial frame leaves nothing pending
  a_drop_empties: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_EXPIRE && result.expired) |-> (result.pending_count == '0))
    else $error("expired answer reports pending bytes");

  // A result not taken stays in place
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind header_sync_fixed_frame_parser hsfp_checker u_hsfp_checker (.*);
